// File: rtl/sgsb_pkg.sv
// ----------------------------------------------------------------------------
// Scatter-gather segment builder package
// Shared widths, codes, descriptor and configuration types.
// ----------------------------------------------------------------------------
package sgsb_pkg;

	localparam int PAGE_SHIFT_DEF = 13;
	localparam int FRAME_W        = 40;
	localparam int ADDR_W         = 64;
	localparam int LEN_W          = 33;
	localparam int SEG_PAGES_W    = 21;
	localparam int WIN_SEG_W      = 16;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 32;
	localparam int QUEUE_DEPTH    = 4;
	localparam int BUNDLE_SLOTS   = 3;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIRECT_MAP_BASE  = 3'd0,
		CFG_MAX_SEG_MINUS1   = 3'd1,
		CFG_MAX_SEGS_PER_WIN = 3'd2,
		CFG_START_OFFSET     = 3'd3,
		CFG_GRANULE_SHIFT    = 3'd4,
		CFG_TRANSFER_LENGTH  = 3'd5
	} cfg_idx_t;

	// Trim applied at the back end of a segment.
	typedef enum logic [1:0] {
		BACK_NONE  = 2'd0,
		BACK_TRUNC = 2'd1,
		BACK_TAIL  = 2'd2
	} back_kind_t;

	// One segment to emit, as classified by the front end.
	typedef struct packed {
		logic                   err;
		logic                   fin;
		logic                   win_end;
		back_kind_t             back;
		logic                   front;
		logic [SEG_PAGES_W-1:0] pages;
		logic [FRAME_W-1:0]     start;
	} desc_t;

	// All segments caused by one page, in emission order.
	typedef struct packed {
		logic [1:0]                   cnt;
		desc_t [BUNDLE_SLOTS-1:0]     d;
	} bundle_t;

	// Configuration values and derived trims.
	typedef struct packed {
		logic [31:0] dmb;
		logic [31:0] msm;
		logic [15:0] sg;
		logic [15:0] off;
		logic        trunc;
		logic [16:0] trunc_back;
		logic [16:0] tail_back;
	} cfg_t;

endpackage

// File: rtl/sgsb_ifs.sv
// ----------------------------------------------------------------------------
// Scatter-gather segment builder channels
// Page input, segment output and configuration write channels.
// ----------------------------------------------------------------------------
interface sgsb_page_if;
	logic                          valid;
	logic                          ready;
	logic [sgsb_pkg::FRAME_W-1:0]  frame_number;
	logic                          last_page;

	modport source (output valid, output frame_number, output last_page, input ready);
	modport sink (input valid, input frame_number, input last_page, output ready);
endinterface

interface sgsb_seg_if;
	logic                         valid;
	logic                         ready;
	logic [sgsb_pkg::ADDR_W-1:0]  segment_address;
	logic [sgsb_pkg::LEN_W-1:0]   segment_length;
	logic                         window_end;
	logic                         final_res;
	logic                         map_error;

	modport source (output valid, output segment_address, output segment_length,
		output window_end, output final_res, output map_error, input ready);
	modport sink (input valid, input segment_address, input segment_length,
		input window_end, input final_res, input map_error, output ready);
endinterface

interface sgsb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sgsb_pkg::CFG_IDX_W-1:0]   index;
	logic [sgsb_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/scatter_gather_segment_builder_top.sv
// ----------------------------------------------------------------------------
// Scatter-gather segment builder
// Merges consecutive page frames into DMA segments grouped into windows.
//
//   channel  direction  beat
//   pages    in         frame_number, last_page
//   segs     out        segment_address, segment_length, window_end,
//                       final_res, map_error
//   cfg      in         index, data (always ready)
//
// One page is accepted every cycle while the four-bundle queue has room.
// Each page yields zero to three segments; the output pipeline emits one
// segment per cycle while the output is ready, so sustained rate is set by
// the segments per page. A page's first segment is written to the queue,
// then registered in back-end stage one and then in the output register.
// Reset clears all control state; output stalls back up through the queue.
// ----------------------------------------------------------------------------
module scatter_gather_segment_builder_top #(
	parameter int PAGE_SHIFT = sgsb_pkg::PAGE_SHIFT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sgsb_page_if.sink   pages,
	sgsb_seg_if.source  segs,
	sgsb_cfg_if.sink    cfg
);
	sgsb_pkg::cfg_t    cv;
	sgsb_pkg::bundle_t push_bundle;
	sgsb_pkg::desc_t   pop_desc;
	logic              push_valid, push_ready, pop_valid, pop_take;

	// Configuration registers.
	sgsb_cfg #(.PAGE_SHIFT(PAGE_SHIFT)) u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cv(cv)
	);

	// Page classification.
	sgsb_front #(.PAGE_SHIFT(PAGE_SHIFT)) u_front (
		.clk(clk), .arst_n(arst_n), .pages(pages), .cv(cv),
		.push_ready(push_ready), .push_valid(push_valid), .push_bundle(push_bundle)
	);

	// Decoupling queue.
	sgsb_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_bundle(push_bundle), .push_ready(push_ready),
		.pop_valid(pop_valid), .pop_desc(pop_desc), .pop_take(pop_take)
	);

	// Segment output pipeline.
	sgsb_back #(.PAGE_SHIFT(PAGE_SHIFT)) u_back (
		.clk(clk), .arst_n(arst_n), .cv(cv),
		.desc_valid(pop_valid), .desc(pop_desc), .desc_take(pop_take), .segs(segs)
	);
endmodule

// File: rtl/sgsb_cfg.sv
// ----------------------------------------------------------------------------
// Scatter-gather configuration registers
// Holds the six registers and registers the trims derived from them.
// ----------------------------------------------------------------------------
module sgsb_cfg #(
	parameter int PAGE_SHIFT = sgsb_pkg::PAGE_SHIFT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	sgsb_cfg_if.sink       cfg,
	output sgsb_pkg::cfg_t cv
);
	localparam logic [15:0] OFF_MASK = 16'((32'd1 << PAGE_SHIFT) - 32'd1);
	localparam logic [16:0] PG_SIZE  = 17'(32'd1 << PAGE_SHIFT);

	logic [31:0] dmb_q, msm_q, tl_q;
	logic [15:0] msw_q;
	logic [12:0] so_q;
	logic [3:0]  gs_q;
	logic [16:0] trunc_back_q, tail_back_q;
	logic [15:0] off;
	logic [32:0] tail_sum;
	logic [16:0] tail_rem;

	assign cfg.ready = 1'b1;

	// Register writes, one beat per register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmb_q <= '0;
			msm_q <= '1;
			msw_q <= '1;
			so_q  <= '0;
			gs_q  <= '0;
			tl_q  <= 32'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sgsb_pkg::CFG_DIRECT_MAP_BASE:  dmb_q <= cfg.data;
				sgsb_pkg::CFG_MAX_SEG_MINUS1:   msm_q <= cfg.data;
				sgsb_pkg::CFG_MAX_SEGS_PER_WIN: msw_q <= cfg.data[15:0];
				sgsb_pkg::CFG_START_OFFSET:     so_q  <= cfg.data[12:0];
				sgsb_pkg::CFG_GRANULE_SHIFT:    gs_q  <= cfg.data[3:0];
				sgsb_pkg::CFG_TRANSFER_LENGTH:  tl_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Offset within the page and the tail remainder of the transfer.
	assign off      = {3'b000, so_q} & OFF_MASK;
	assign tail_sum = 33'(off) + 33'(tl_q);
	assign tail_rem = 17'(tail_sum & 33'(OFF_MASK));

	// The back trims are registered; they are only used by the output pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trunc_back_q <= '0;
			tail_back_q  <= '0;
		end else begin
			trunc_back_q <= PG_SIZE - 17'(off);
			tail_back_q  <= (tail_rem != '0) ? PG_SIZE - tail_rem : '0;
		end
	end

	assign cv.dmb        = dmb_q;
	assign cv.msm        = msm_q;
	assign cv.sg         = (msw_q == '0) ? 16'd1 : msw_q;
	assign cv.off        = off;
	assign cv.trunc      = |(off & ~(16'hFFFF << gs_q));
	assign cv.trunc_back = trunc_back_q;
	assign cv.tail_back  = tail_back_q;
endmodule

// File: rtl/sgsb_front.sv
// ----------------------------------------------------------------------------
// Scatter-gather front end
// Accepts one page a beat while the queue has room, tracks segment and
// window state and classifies the segments the page closes into a queue bundle.
// ----------------------------------------------------------------------------
module sgsb_front #(
	parameter int PAGE_SHIFT = sgsb_pkg::PAGE_SHIFT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	sgsb_page_if.sink         pages,
	input  sgsb_pkg::cfg_t    cv,
	input  logic              push_ready,
	output logic              push_valid,
	output sgsb_pkg::bundle_t push_bundle
);
	localparam int SPW = sgsb_pkg::SEG_PAGES_W;
	localparam int FW  = sgsb_pkg::FRAME_W;
	localparam int CW  = SPW + PAGE_SHIFT;

	logic [FW-1:0]  pf_q, sf_q, pf_n, sf_n;
	logic [SPW-1:0] sp_q, sp_n;
	logic [15:0]    wsc_q, wsc_n;
	logic [1:0]     wpc_q, wpc_n;
	logic           fow_q, fot_q, failed_q, fow_n, fot_n, failed_n;
	logic           accept, cons, fits0, fits1, adv0;
	logic [16:0]    wsc1;
	logic [1:0]     wpc_inc;
	sgsb_pkg::bundle_t bnd;

	function automatic sgsb_pkg::desc_t mk(input logic [FW-1:0] start,
		input logic [SPW-1:0] pg, input logic fr, input sgsb_pkg::back_kind_t bk,
		input logic we, input logic fin);
		sgsb_pkg::desc_t d;
		d.err     = 1'b0;
		d.fin     = fin;
		d.win_end = we;
		d.back    = bk;
		d.front   = fr;
		d.pages   = pg;
		d.start   = start;
		return d;
	endfunction

	assign pages.ready = push_ready;
	assign accept      = pages.valid & push_ready;

	// Contiguity and size checks for both passes over the page.
	assign cons    = (pf_q != '1) && (pages.frame_number == pf_q + FW'(1));
	assign fits0   = {sp_q, {PAGE_SHIFT{1'b1}}} <= CW'(cv.msm);
	assign fits1   = {SPW'(1), {PAGE_SHIFT{1'b1}}} <= CW'(cv.msm);
	assign wsc1    = {1'b0, wsc_q} + 17'd1;
	assign adv0    = wsc1 < {1'b0, cv.sg};
	assign wpc_inc = (wpc_q == 2'd2) ? 2'd2 : wpc_q + 2'd1;

	// Next state and the bundle of segments this page closes.
	always_comb begin
		logic err_hit;
		err_hit  = 1'b0;
		pf_n     = pf_q;
		sf_n     = sf_q;
		sp_n     = sp_q;
		wsc_n    = wsc_q;
		wpc_n    = wpc_q;
		fow_n    = fow_q;
		fot_n    = fot_q;
		failed_n = failed_q;
		bnd      = '0;
		if (accept) begin
			if (failed_q) begin
				if (pages.last_page) begin
					sp_n = '0; wsc_n = '0; wpc_n = '0;
					fow_n = 1'b1; fot_n = 1'b1; failed_n = 1'b0;
				end
			end else begin
				if (sp_q == '0) begin
					sf_n = pages.frame_number; pf_n = pages.frame_number;
					sp_n = SPW'(1); wsc_n = '0; wpc_n = 2'd1;
					fow_n = 1'b1; fot_n = 1'b1;
				end else if (cons && fits0) begin
					sp_n = sp_q + SPW'(1); wpc_n = wpc_inc; pf_n = pages.frame_number;
				end else if (adv0) begin
					bnd.d[bnd.cnt] = mk(sf_q, sp_q, fot_q | (fow_q & cv.trunc),
						sgsb_pkg::BACK_NONE, 1'b0, 1'b0);
					bnd.cnt = bnd.cnt + 2'd1;
					fow_n = 1'b0; fot_n = 1'b0;
					sf_n = pages.frame_number; pf_n = pages.frame_number;
					sp_n = SPW'(1); wpc_n = wpc_inc; wsc_n = wsc1[15:0];
				end else if (cv.trunc && wpc_q == 2'd1) begin
					err_hit = 1'b1;
				end else begin
					// Window is full: close it.
					bnd.d[bnd.cnt] = mk(sf_q, sp_q, fot_q | (fow_q & cv.trunc),
						cv.trunc ? sgsb_pkg::BACK_TRUNC : sgsb_pkg::BACK_NONE,
						1'b1, 1'b0);
					bnd.cnt = bnd.cnt + 2'd1;
					wsc_n = '0; fow_n = 1'b1; fot_n = 1'b0;
					if (!cv.trunc) begin
						sf_n = pages.frame_number; pf_n = pages.frame_number;
						sp_n = SPW'(1); wpc_n = 2'd1;
					end else if (cons && fits1) begin
						// New window restarts on the shared page and runs on.
						sf_n = pf_q; sp_n = SPW'(2); wpc_n = 2'd2;
						pf_n = pages.frame_number;
					end else if (cv.sg != 16'd1) begin
						bnd.d[bnd.cnt] = mk(pf_q, SPW'(1), 1'b1, sgsb_pkg::BACK_NONE,
							1'b0, 1'b0);
						bnd.cnt = bnd.cnt + 2'd1;
						fow_n = 1'b0; fot_n = 1'b0;
						sf_n = pages.frame_number; pf_n = pages.frame_number;
						sp_n = SPW'(1); wpc_n = 2'd2; wsc_n = 16'd1;
					end else begin
						err_hit = 1'b1;
					end
				end
				if (err_hit) begin
					bnd.d[bnd.cnt]     = '0;
					bnd.d[bnd.cnt].err = 1'b1;
					bnd.d[bnd.cnt].fin = 1'b1;
					bnd.cnt = bnd.cnt + 2'd1;
					failed_n = 1'b1;
				end else if (pages.last_page) begin
					bnd.d[bnd.cnt] = mk(sf_n, sp_n, fot_n | (fow_n & cv.trunc),
						sgsb_pkg::BACK_TAIL, 1'b1, 1'b1);
					bnd.cnt = bnd.cnt + 2'd1;
				end
				if (pages.last_page) begin
					sp_n = '0; wsc_n = '0; wpc_n = '0;
					fow_n = 1'b1; fot_n = 1'b1; failed_n = 1'b0;
				end
			end
		end
	end

	assign push_valid  = accept && (bnd.cnt != 2'd0);
	assign push_bundle = bnd;

	// Transfer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_q     <= '0;
			sf_q     <= '0;
			sp_q     <= '0;
			wsc_q    <= '0;
			wpc_q    <= '0;
			fow_q    <= 1'b1;
			fot_q    <= 1'b1;
			failed_q <= 1'b0;
		end else begin
			pf_q     <= pf_n;
			sf_q     <= sf_n;
			sp_q     <= sp_n;
			wsc_q    <= wsc_n;
			wpc_q    <= wpc_n;
			fow_q    <= fow_n;
			fot_q    <= fot_n;
			failed_q <= failed_n;
		end
	end
endmodule

// File: rtl/sgsb_queue.sv
// ----------------------------------------------------------------------------
// Scatter-gather descriptor queue
// Holds front-end bundles and hands them out one segment a beat when taken.
// ----------------------------------------------------------------------------
module sgsb_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	input  sgsb_pkg::bundle_t push_bundle,
	output logic              push_ready,
	output logic              pop_valid,
	output sgsb_pkg::desc_t   pop_desc,
	input  logic              pop_take
);
	localparam int DEPTH = sgsb_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	sgsb_pkg::bundle_t    mem_q [DEPTH];
	logic [PW-1:0]        wr_q, rd_q;
	logic [PW:0]          count_q;
	logic [1:0]           sub_q;
	logic                 push, pop_bundle;
	sgsb_pkg::bundle_t    head;

	assign head       = mem_q[rd_q];
	assign push_ready = count_q != (PW+1)'(DEPTH);
	assign push       = push_valid & push_ready;
	assign pop_valid  = count_q != '0;
	assign pop_desc   = head.d[sub_q];
	assign pop_bundle = pop_valid & pop_take & (sub_q == head.cnt - 2'd1);

	// Bundle storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_bundle;
		end
	end

	// Pointers, fill count and the segment index within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
			sub_q   <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop_bundle) begin
				rd_q  <= rd_q + PW'(1);
				sub_q <= '0;
			end else if (pop_valid & pop_take) begin
				sub_q <= sub_q + 2'd1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop_bundle);
		end
	end
endmodule

// File: rtl/sgsb_back.sv
// ----------------------------------------------------------------------------
// Scatter-gather back end
// Two-stage pipeline turning segment descriptors into bus address and
// trimmed length; the second stage is the output register.
// ----------------------------------------------------------------------------
module sgsb_back #(
	parameter int PAGE_SHIFT = sgsb_pkg::PAGE_SHIFT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sgsb_pkg::cfg_t  cv,
	input  logic            desc_valid,
	input  sgsb_pkg::desc_t desc,
	output logic            desc_take,
	sgsb_seg_if.source      segs
);
	localparam int AW = sgsb_pkg::ADDR_W;
	localparam int LW = sgsb_pkg::LEN_W;

	logic                  valid_s1, valid_s2;
	logic [AW-1:0]         addr_s1, addr_s2;
	logic [LW-1:0]         len_s1, len_s2;
	sgsb_pkg::back_kind_t  back_s1;
	logic                  we_s1, fin_s1, err_s1, we_s2, fin_s2, err_s2;
	logic                  out_take, load_s1;
	logic [PAGE_SHIFT-1:0] front_off;
	logic [AW-1:0]         addr_n;
	logic [LW-1:0]         len0, fv, len1, bv, len2;

	assign out_take  = !valid_s2 | segs.ready;
	assign load_s1   = !valid_s1 | out_take;
	assign desc_take = desc_valid & load_s1;

	// Stage one: address and front trim.
	assign front_off = desc.front ? cv.off[PAGE_SHIFT-1:0] : '0;
	assign addr_n    = AW'({desc.start, front_off}) + AW'(cv.dmb);
	assign len0      = LW'({desc.pages, {PAGE_SHIFT{1'b0}}});
	assign fv        = desc.front ? LW'(cv.off) : '0;
	assign len1      = (len0 > fv) ? len0 - fv : '0;

	// Stage two: back trim.
	always_comb begin
		case (back_s1)
			sgsb_pkg::BACK_TRUNC: bv = LW'(cv.trunc_back);
			sgsb_pkg::BACK_TAIL:  bv = LW'(cv.tail_back);
			default:              bv = '0;
		endcase
	end
	assign len2 = (len_s1 > bv) ? len_s1 - bv : '0;

	// Pipeline valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= desc_valid;
			end
			if (out_take) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Pipeline payload; an error beat carries zeros.
	always_ff @(posedge clk) begin
		if (desc_take) begin
			addr_s1 <= desc.err ? '0 : addr_n;
			len_s1  <= desc.err ? '0 : len1;
			back_s1 <= desc.err ? sgsb_pkg::BACK_NONE : desc.back;
			we_s1   <= desc.win_end;
			fin_s1  <= desc.fin;
			err_s1  <= desc.err;
		end
		if (valid_s1 & out_take) begin
			addr_s2 <= addr_s1;
			len_s2  <= len2;
			we_s2   <= we_s1;
			fin_s2  <= fin_s1;
			err_s2  <= err_s1;
		end
	end

	assign segs.valid           = valid_s2;
	assign segs.segment_address = addr_s2;
	assign segs.segment_length  = len_s2;
	assign segs.window_end      = we_s2;
	assign segs.final_res       = fin_s2;
	assign segs.map_error       = err_s2;
endmodule
